@@ hw/rtl/nch_pkg.sv @@
// shared constants and types for the nearest-centroid hamming search block
package nch_pkg;

  localparam int MAX_CLUSTERS_DEF  = 1024;
  localparam int MAX_SIG_WORDS_DEF = 4;

  localparam int WORD_W   = 64;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int SWC_W    = 3;
  localparam int DIST_W   = 9;
  localparam int NUM_IN_WORDS = 4;

  localparam int IN_TDATA_W  = 272;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_WORDS     = 2'd1;

  localparam logic [CNT_W-1:0] CLUSTER_COUNT_RST = 11'd1000;
  localparam logic [SWC_W-1:0] SIG_WORDS_RST     = 3'd4;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = 9'd256;

  // tag that travels with each centroid read down the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [CNT_W-1:0] idx;
  } tag_t;

endpackage

@@ hw/rtl/nearest_centroid_hamming_search.sv @@
// top level of the nearest-centroid hamming search block
// A load item (tuser 0) writes one centroid entry in the cycle it is accepted and gives no
// result; the block is ready again on the next cycle. A classify item (tuser 1) latches its
// signature and scans centroids 0 to cluster_count-1 (as clamped), one memory read per
// cycle from the centroid RAM (one write port, one read port), so a classification holds
// the input from its accept to the next accept: the scan itself plus the RAM read, two
// distance stages, the end-of-scan check, and the result hand-off, at which the result
// becomes valid. The result sits in an output register;
// a new item is taken while it waits, and only a second classify that finishes before the
// first result is taken stalls at its end. Ties keep the lowest index. The centroid RAM has
// no reset, so every entry in the searched range must be loaded before a classify.
module nearest_centroid_hamming_search #(
  parameter int MAX_CLUSTERS  = nch_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_SIG_WORDS = nch_pkg::MAX_SIG_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // entry_index[9:0], sig_word0[73:10], sig_word1[137:74], sig_word2[201:138],
  // sig_word3[265:202], zero pad[271:266]
  input  logic [nch_pkg::IN_TDATA_W-1:0] s_tdata,
  // operation[0]
  input  logic                           s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // best_cluster[9:0], best_distance[18:10], zero pad[23:19]
  output logic [nch_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [nch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nch_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DW = MAX_SIG_WORDS * nch_pkg::WORD_W;
  localparam int IN_SIG_LSB = nch_pkg::IDX_W;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    FLUSH
  } state_t;

  state_t state;

  // configuration registers
  logic [nch_pkg::CNT_W-1:0] cluster_count;
  logic [nch_pkg::SWC_W-1:0] sig_words;

  // per-classify working registers
  logic [DW-1:0]              sig;
  logic [nch_pkg::CNT_W-1:0]  scan_last;
  logic [nch_pkg::CNT_W-1:0]  scan_idx;
  logic [nch_pkg::SWC_W-1:0]  n_words;
  nch_pkg::tag_t              tag_rd;

  // running best
  logic [nch_pkg::DIST_W-1:0] best_dist;
  logic [nch_pkg::CNT_W-1:0]  best_idx;

  // input item fields
  logic                      in_accept;
  logic [nch_pkg::IDX_W-1:0] entry_index;
  logic [DW-1:0]             in_sig;

  // clamped settings for the item being accepted
  logic [nch_pkg::CNT_W-1:0] n_clusters;
  logic [nch_pkg::SWC_W-1:0] n_words_next;

  // memory ports
  logic          wr_en;
  logic          rd_en;
  logic [DW-1:0] rd_data;

  // distance pipe outputs
  nch_pkg::tag_t              tag_dist;
  logic [nch_pkg::DIST_W-1:0] cand_dist;
  logic                       take_best;

  assign s_tready    = (state == IDLE);
  assign in_accept   = s_tvalid && s_tready;
  assign entry_index = s_tdata[nch_pkg::IDX_W-1:0];

  // the RAM only holds the words that can ever be compared
  always_comb begin
    for (int w = 0; w < MAX_SIG_WORDS; w++) begin
      in_sig[w*nch_pkg::WORD_W +: nch_pkg::WORD_W] =
        s_tdata[IN_SIG_LSB + w*nch_pkg::WORD_W +: nch_pkg::WORD_W];
    end
  end

  // loads past the table are dropped
  assign wr_en = in_accept && (s_tuser == nch_pkg::OP_LOAD) && (entry_index < MAX_CLUSTERS);

  // count 0 searches entry 0 only; both settings clamp to the table
  always_comb begin
    if (cluster_count == '0) begin
      n_clusters = nch_pkg::CNT_W'(1);
    end else if (cluster_count > MAX_CLUSTERS) begin
      n_clusters = nch_pkg::CNT_W'(MAX_CLUSTERS);
    end else begin
      n_clusters = cluster_count;
    end
    if (sig_words == '0) begin
      n_words_next = nch_pkg::SWC_W'(1);
    end else if (sig_words > MAX_SIG_WORDS) begin
      n_words_next = nch_pkg::SWC_W'(MAX_SIG_WORDS);
    end else begin
      n_words_next = sig_words;
    end
  end

  assign rd_en = (state == SCAN);

  nch_store #(
    .MAX_CLUSTERS  (MAX_CLUSTERS),
    .MAX_SIG_WORDS (MAX_SIG_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (in_sig),
    .rd_en   (rd_en),
    .rd_addr (AW'(scan_idx)),
    .rd_data (rd_data)
  );

  nch_dist #(
    .MAX_SIG_WORDS (MAX_SIG_WORDS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .n_words   (n_words),
    .sig       (sig),
    .cent      (rd_data),
    .tag_in    (tag_rd),
    .tag_out   (tag_dist),
    .cand_dist (cand_dist)
  );

  // first entry always seeds the best; later ones must be strictly closer
  assign take_best = tag_dist.valid && (tag_dist.first || (cand_dist < best_dist));

  // configuration writes, taken at any time the port is strobed
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= nch_pkg::CLUSTER_COUNT_RST;
      sig_words     <= nch_pkg::SIG_WORDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nch_pkg::REG_CLUSTER_COUNT: cluster_count <= cfg_data;
        nch_pkg::REG_SIG_WORDS:     sig_words     <= cfg_data[nch_pkg::SWC_W-1:0];
        default: ;
      endcase
    end
  end

  // classify payload, captured at accept
  always_ff @(posedge clk) begin
    if (in_accept && (s_tuser == nch_pkg::OP_CLASSIFY)) begin
      sig       <= in_sig;
      scan_last <= n_clusters - nch_pkg::CNT_W'(1);
      n_words   <= n_words_next;
    end
    if (take_best) begin
      best_dist <= cand_dist;
      best_idx  <= tag_dist.idx;
    end
  end

  // sequencer, read tag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      scan_idx <= '0;
      tag_rd   <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (state != SCAN) begin
        tag_rd <= '0;
      end
      // the flush arm owns the output register while it hands off
      if (m_tvalid && m_tready && (state != FLUSH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          scan_idx <= '0;
          if (in_accept && (s_tuser == nch_pkg::OP_CLASSIFY)) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          // one centroid read per cycle; the tag lines up with the read data
          tag_rd.valid <= 1'b1;
          tag_rd.first <= (scan_idx == '0);
          tag_rd.last  <= (scan_idx == scan_last);
          tag_rd.idx   <= scan_idx;
          scan_idx     <= scan_idx + nch_pkg::CNT_W'(1);
          if (scan_idx == scan_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (tag_dist.valid && tag_dist.last) begin
            state <= FLUSH;
          end
        end
        FLUSH: begin
          // wait for the output register to be free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(nch_pkg::OUT_TDATA_W - nch_pkg::DIST_W - nch_pkg::IDX_W){1'b0}},
                         best_dist, best_idx[nch_pkg::IDX_W-1:0]};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/nch_store.sv @@
// centroid memory: one write port, one read port with registered read data
module nch_store #(
  parameter int MAX_CLUSTERS  = nch_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_SIG_WORDS = nch_pkg::MAX_SIG_WORDS_DEF,
  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int DW = MAX_SIG_WORDS * nch_pkg::WORD_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [MAX_CLUSTERS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/nch_dist.sv @@
// two-stage distance pipe: per-word xor popcount, then masked word sum
module nch_dist #(
  parameter int MAX_SIG_WORDS = nch_pkg::MAX_SIG_WORDS_DEF,
  localparam int DW = MAX_SIG_WORDS * nch_pkg::WORD_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [nch_pkg::SWC_W-1:0] n_words,
  input  logic [DW-1:0]             sig,
  input  logic [DW-1:0]             cent,
  input  nch_pkg::tag_t             tag_in,
  output nch_pkg::tag_t             tag_out,
  output logic [nch_pkg::DIST_W-1:0] cand_dist
);

  localparam int POP_W = 7;

  // swar popcount: pairs, nibbles, bytes, then a sum of eight bytes
  function automatic logic [POP_W-1:0] popcount64(input logic [63:0] v);
    logic [63:0] x;
    logic [POP_W-1:0] s;
    x = v - ((v >> 1) & 64'h5555555555555555);
    x = (x & 64'h3333333333333333) + ((x >> 2) & 64'h3333333333333333);
    x = (x + (x >> 4)) & 64'h0F0F0F0F0F0F0F0F;
    s = '0;
    for (int b = 0; b < 8; b++) begin
      s = s + POP_W'(x[b*8 +: 4]);
    end
    return s;
  endfunction

  logic [POP_W-1:0] pop [MAX_SIG_WORDS];
  nch_pkg::tag_t    tag1;
  logic [nch_pkg::DIST_W-1:0] sum_next;

  always_ff @(posedge clk) begin
    for (int w = 0; w < MAX_SIG_WORDS; w++) begin
      pop[w] <= popcount64(sig[w*nch_pkg::WORD_W +: nch_pkg::WORD_W]
                           ^ cent[w*nch_pkg::WORD_W +: nch_pkg::WORD_W]);
    end
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1 <= tag_in;
    end
  end

  always_comb begin
    sum_next = '0;
    for (int w = 0; w < MAX_SIG_WORDS; w++) begin
      if (nch_pkg::SWC_W'(w) < n_words) begin
        sum_next = sum_next + nch_pkg::DIST_W'(pop[w]);
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_dist <= sum_next;
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag1;
    end
  end

endmodule

@@ hw/rtl/nch_checker.sv @@
// port-level checks for the nearest-centroid hamming search block, with bind
module nch_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tuser,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [nch_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready
);

  // a classify item occupies the block for at least the scan
  a_classify_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == nch_pkg::OP_CLASSIFY) |=> !s_tready)
    else $error("ready after classify accept");

  // a load item completes in its accept cycle
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == nch_pkg::OP_LOAD) |=> s_tready)
    else $error("not ready after load accept");

  // distance cannot exceed the signature length
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[18:10] <= nch_pkg::DIST_MAX))
    else $error("distance out of range");

  // pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:19] == '0))
    else $error("result pad bits set");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind nearest_centroid_hamming_search nch_checker u_nch_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tuser  (s_tuser),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// testbench for the nearest-centroid hamming search: predicts each nearest match and checks the result stream
module tb;

  localparam int SIG_W = nch_pkg::WORD_W * nch_pkg::NUM_IN_WORDS;
  localparam int PAD_W = nch_pkg::IN_TDATA_W - nch_pkg::IDX_W - SIG_W;
  localparam int IDX_W = nch_pkg::IDX_W;
  localparam int DIST_W = nch_pkg::DIST_W;
  localparam int WORD_W = nch_pkg::WORD_W;
  localparam int CFG_DATA_W = nch_pkg::CFG_DATA_W;
  localparam int MAX_ENTRIES = nch_pkg::MAX_CLUSTERS_DEF;

  // register indexes the block has no register behind
  localparam logic [nch_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [nch_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // a classify is done once its result is out, a load in the cycle it is taken;
  // this margin covers the pipeline tail before any register write
  localparam int SETTLE_CYCLES = 16;
  // a full 1024-entry scan plus result stalls stays far below this
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTINGS_PER_PHASE = 6;
  localparam int ITEMS_PER_SETTING = 24;

  typedef struct packed {
    logic [IDX_W-1:0]  cluster;
    logic [DIST_W-1:0] distance;
  } match_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [nch_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = nch_pkg::OP_LOAD;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [nch_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [nch_pkg::CFG_IDX_W-1:0]   cfg_index = nch_pkg::REG_CLUSTER_COUNT;
  logic [CFG_DATA_W-1:0]           cfg_data = '0;

  // shadow of the block: centroid table and the two registers
  logic [SIG_W-1:0]          centroid_copy [MAX_ENTRIES];
  bit                        entry_written [MAX_ENTRIES];
  logic [nch_pkg::CNT_W-1:0] count_reg = nch_pkg::CLUSTER_COUNT_RST;
  logic [nch_pkg::SWC_W-1:0] words_reg = nch_pkg::SIG_WORDS_RST;

  match_t      expected_matches[$];
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  nearest_centroid_hamming_search DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // number of entries one classify scans, after clamping
  function automatic int unsigned search_span();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(count_reg);
  endfunction

  function automatic int unsigned word_span();
    if (words_reg == 0) return 1;
    if (words_reg > nch_pkg::MAX_SIG_WORDS_DEF) return nch_pkg::MAX_SIG_WORDS_DEF;
    return int'(words_reg);
  endfunction

  // scan the shadow table; strict less-than keeps the lowest index on ties
  function automatic match_t nearest_centroid(input logic [SIG_W-1:0] sig);
    logic [SIG_W-1:0] mask;
    int unsigned      diff_bits;
    int unsigned      best_bits;
    match_t           found;
    mask = '0;
    for (int w = 0; w < word_span(); w++) mask[w*WORD_W +: WORD_W] = '1;
    best_bits = 0;
    found = '0;
    for (int c = 0; c < search_span(); c++) begin
      diff_bits = $countones((sig ^ centroid_copy[c]) & mask);
      if (c == 0 || diff_bits < best_bits) begin
        best_bits = diff_bits;
        found.cluster = IDX_W'(c);
      end
    end
    found.distance = DIST_W'(best_bits);
    return found;
  endfunction

  function automatic logic [SIG_W-1:0] random_sig();
    logic [SIG_W-1:0] s;
    for (int i = 0; i < SIG_W / 32; i++) s[i*32 +: 32] = $urandom;
    return s;
  endfunction

  function automatic logic [SIG_W-1:0] flip_bits(input logic [SIG_W-1:0] s,
                                                 input int unsigned flips);
    int unsigned pos;
    for (int i = 0; i < flips; i++) begin
      pos = $urandom_range(SIG_W - 1);
      s[pos] = ~s[pos];
    end
    return s;
  endfunction

  // all zeros, all ones, alternating bits, or half and half
  function automatic logic [SIG_W-1:0] pattern_sig();
    case ($urandom_range(3))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return {(SIG_W/2){2'b10}};
      end
      default: begin
        return {{(SIG_W/2){1'b1}}, {(SIG_W/2){1'b0}}};
      end
    endcase
  endfunction

  // one item on the input stream; valid stays high after acceptance so the
  // next call can follow without a bubble
  task automatic send_item(input logic op, input logic [IDX_W-1:0] entry,
                           input logic [SIG_W-1:0] sig);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{PAD_W{1'b0}}, sig, entry};
    do @(posedge clk); while (!s_tready);
    if (op == nch_pkg::OP_LOAD) begin
      centroid_copy[entry] = sig;
      entry_written[entry] = 1'b1;
    end else begin
      expected_matches.insert(expected_matches.size(), nearest_centroid(sig));
    end
  endtask

  // load every entry below span that was never written since reset
  task automatic fill_entries(input int unsigned span);
    for (int c = 0; c < span; c++) begin
      if (!entry_written[c]) send_item(nch_pkg::OP_LOAD, IDX_W'(c), random_sig());
    end
  endtask

  // entry_index is ignored on classify, so it carries noise
  task automatic classify(input logic [SIG_W-1:0] sig);
    fill_entries(search_span());
    send_item(nch_pkg::OP_CLASSIFY, IDX_W'($urandom_range(MAX_ENTRIES - 1)), sig);
  endtask

  // hold off the sender until every result is in and the pipeline is empty
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_reg(input logic [nch_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      nch_pkg::REG_CLUSTER_COUNT: begin
        count_reg = value[nch_pkg::CNT_W-1:0];
      end
      nch_pkg::REG_SIG_WORDS: begin
        words_reg = value[nch_pkg::SWC_W-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic set_search(input logic [CFG_DATA_W-1:0] count,
                            input logic [CFG_DATA_W-1:0] words);
    drain_results();
    write_reg(nch_pkg::REG_CLUSTER_COUNT, count);
    write_reg(nch_pkg::REG_SIG_WORDS, words);
  endtask

  // result side: random stalls, compare against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_matches.size() == 0) begin
          $error("result with no classify pending: best_cluster %0d best_distance %0d",
                 m_tdata[IDX_W-1:0], m_tdata[IDX_W +: DIST_W]);
          fail_count++;
        end else begin
          if (m_tdata[IDX_W-1:0] !== expected_matches[0].cluster) begin
            $error("best_cluster mismatch: expected %0d, got %0d",
                   expected_matches[0].cluster, m_tdata[IDX_W-1:0]);
            fail_count++;
          end
          if (m_tdata[IDX_W +: DIST_W] !== expected_matches[0].distance) begin
            $error("best_distance mismatch: expected %0d, got %0d",
                   expected_matches[0].distance, m_tdata[IDX_W +: DIST_W]);
            fail_count++;
          end
          void'(expected_matches.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // no item moving on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // reset values: 1000 entries, all four words
  task automatic test_reset_settings();
    fill_entries(search_span());
    classify(random_sig());
    classify(centroid_copy[517]);
    classify(~centroid_copy[3]);
  endtask

  // cluster_count of zero scans entry 0 only; anything above the table is clamped
  task automatic test_count_limits();
    drain_results();
    write_reg(nch_pkg::REG_CLUSTER_COUNT, '0);
    classify(random_sig());
    drain_results();
    write_reg(nch_pkg::REG_CLUSTER_COUNT, '1);
    fill_entries(MAX_ENTRIES);
    classify(centroid_copy[MAX_ENTRIES-1]);
    drain_results();
    write_reg(nch_pkg::REG_CLUSTER_COUNT, CFG_DATA_W'(MAX_ENTRIES));
    classify(~centroid_copy[0]);
    drain_results();
    write_reg(nch_pkg::REG_CLUSTER_COUNT, CFG_DATA_W'(1));
    classify(flip_bits(centroid_copy[0], 3));
  endtask

  // word count clamping, masking of the upper data bits, writes to unused indexes
  task automatic test_word_limits();
    logic [SIG_W-1:0] low_match;
    // matches entry 5 in the low word only
    low_match = centroid_copy[5] ^ {{(SIG_W-WORD_W){1'b1}}, {WORD_W{1'b0}}};
    set_search(CFG_DATA_W'(8), '0);
    classify(low_match);
    drain_results();
    write_reg(nch_pkg::REG_SIG_WORDS, CFG_DATA_W'(7));
    classify(low_match);
    drain_results();
    write_reg(nch_pkg::REG_SIG_WORDS, CFG_DATA_W'(11'h7FA));
    classify(low_match);
    drain_results();
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '0);
    classify(flip_bits(low_match, 1));
  endtask

  // ties, zero and full distance, and words stored beyond the active count
  task automatic test_ties_and_extremes();
    set_search(CFG_DATA_W'(4), CFG_DATA_W'(4));
    send_item(nch_pkg::OP_LOAD, IDX_W'(0), '1);
    send_item(nch_pkg::OP_LOAD, IDX_W'(1), '0);
    send_item(nch_pkg::OP_LOAD, IDX_W'(2), '0);
    send_item(nch_pkg::OP_LOAD, IDX_W'(3), random_sig());
    classify('0);
    classify('1);
    classify({1'b1, {(SIG_W-1){1'b0}}});
    drain_results();
    write_reg(nch_pkg::REG_CLUSTER_COUNT, CFG_DATA_W'(1));
    classify('0);
    // a load keeps all four words even while only one is compared
    drain_results();
    write_reg(nch_pkg::REG_SIG_WORDS, CFG_DATA_W'(1));
    send_item(nch_pkg::OP_LOAD, IDX_W'(0), {{(SIG_W-WORD_W){1'b1}}, {WORD_W{1'b0}}});
    classify('0);
    drain_results();
    write_reg(nch_pkg::REG_SIG_WORDS, CFG_DATA_W'(4));
    classify('0);
  endtask

  // random settings and traffic under four idling profiles; signatures mostly sit
  // close to stored centroids so ties and small distances come up often
  task automatic test_random_traffic();
    int unsigned               pick;
    int unsigned               span;
    logic [nch_pkg::CNT_W-1:0] count;
    logic [SIG_W-1:0]          sig;
    logic [SIG_W-1:0]          noise;
    logic [IDX_W-1:0]          entry;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 74;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 74;
        end
        default: begin
          gap_pct = 37;
          stall_pct = 37;
        end
      endcase
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        // mostly short scans, now and then the clamped ends
        pick = $urandom_range(99);
        if (pick < 60) count = nch_pkg::CNT_W'($urandom_range(16, 1));
        else if (pick < 85) count = nch_pkg::CNT_W'($urandom_range(96, 17));
        else if (pick < 92) count = nch_pkg::CNT_W'($urandom_range(1));
        else count = nch_pkg::CNT_W'($urandom_range(2047, 1000));
        set_search(CFG_DATA_W'(count), CFG_DATA_W'($urandom_range(2047)));
        if ($urandom_range(3) == 0) begin
          write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                    CFG_DATA_W'($urandom_range(2047)));
        end
        span = search_span();
        for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
          pick = $urandom_range(99);
          noise = random_sig();
          if (pick < 45) sig = flip_bits(centroid_copy[$urandom_range(span - 1)],
                                         $urandom_range(6));
          else if (pick < 70) sig = noise;
          else if (pick < 85) sig = pattern_sig();
          else sig = {noise[SIG_W-1:WORD_W],
                      centroid_copy[$urandom_range(span - 1)][WORD_W-1:0]};
          if ($urandom_range(1) == 0) begin
            // loads land mostly inside the searched range
            if ($urandom_range(99) < 75) entry = IDX_W'($urandom_range(span - 1));
            else entry = IDX_W'($urandom_range(MAX_ENTRIES - 1));
            send_item(nch_pkg::OP_LOAD, entry, sig);
          end else begin
            classify(sig);
          end
          if ($urandom_range(39) == 0) drain_results();
        end
      end
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_count_limits();
    test_word_limits();
    test_ties_and_extremes();
    test_random_traffic();
    drain_results();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/nch_pkg.sv
hw/rtl/nch_store.sv
hw/rtl/nch_dist.sv
hw/rtl/nearest_centroid_hamming_search.sv
hw/rtl/nch_checker.sv
verif/tb.sv
